@@ src/gspf_pkg.sv @@
// package: constants, register codes and reset values of the projection filter
`timescale 1ns / 1ps
package gspf_pkg;

  localparam int MAX_DIMS_DEF = 4;
  localparam int ID_BITS_DEF  = 32;
  localparam int STEP_BITS    = 8;

  localparam int PEER_W     = 32;
  localparam int CONC_W     = 16;
  localparam int GRID_W     = 64;
  localparam int DIMC_W     = 3;
  localparam int MASK_W     = 5;
  localparam int OWN_W      = 32;
  localparam int RADIX_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONC  = 3'd0,
    CFG_GRID  = 3'd1,
    CFG_DIMC  = 3'd2,
    CFG_MASK  = 3'd3,
    CFG_OWN   = 3'd4
  } cfg_reg_t;

  localparam logic [CONC_W-1:0] CONC_RST = 16'd1;
  localparam logic [GRID_W-1:0] GRID_RST = 64'h0001_0001_0001_0001;
  localparam logic [DIMC_W-1:0] DIMC_RST = 3'd2;
  localparam logic [MASK_W-1:0] MASK_RST = 5'd0;
  localparam logic [OWN_W-1:0]  OWN_RST  = 32'd0;

endpackage

@@ src/gspf_if.sv @@
// interfaces: peer input, result output and register write channels
`timescale 1ns / 1ps
interface gspf_in_if import gspf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PEER_W-1:0] peer_id;
  logic              last_in;
  modport source (output valid, peer_id, last_in, input ready);
  modport sink (input valid, peer_id, last_in, output ready);
endinterface

interface gspf_out_if import gspf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PEER_W-1:0] peer_out;
  logic              keep;
  logic              last_out;
  modport source (output valid, peer_out, keep, last_out, input ready);
  modport sink (input valid, peer_out, keep, last_out, output ready);
endinterface

interface gspf_cfg_if import gspf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/grid_subgroup_projection_filter.sv @@
// throughput: one peer id per cycle while the output is not back-pressured,
// up to eight quotient bits per pipeline stage
// after every register write the own coordinates are rebuilt one bit a cycle,
// during which no input beat is taken
// reset (synchronous, rst_n low): registers to defaults, pipeline empty
`timescale 1ns / 1ps
module grid_subgroup_projection_filter import gspf_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  gspf_in_if.sink   in_bus,
  gspf_out_if.source out_bus,
  gspf_cfg_if.sink  cfg_bus
);

  localparam int NDIG = MAX_DIMS + 1;

  logic [CONC_W-1:0] conc_r;
  logic [GRID_W-1:0] grid_r;
  logic [DIMC_W-1:0] dimc_r;
  logic [MASK_W-1:0] mask_r;
  logic [OWN_W-1:0]  own_r;
  logic              start_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conc_r  <= CONC_RST;
      grid_r  <= GRID_RST;
      dimc_r  <= DIMC_RST;
      mask_r  <= MASK_RST;
      own_r   <= OWN_RST;
      start_r <= 1'b0;
    end else begin
      start_r <= cfg_bus.valid;
      if (cfg_bus.valid) begin
        unique case (cfg_bus.index)
          CFG_CONC: conc_r <= cfg_bus.data[CONC_W-1:0];
          CFG_GRID: grid_r <= cfg_bus.data[GRID_W-1:0];
          CFG_DIMC: dimc_r <= cfg_bus.data[DIMC_W-1:0];
          CFG_MASK: mask_r <= cfg_bus.data[MASK_W-1:0];
          CFG_OWN:  own_r  <= cfg_bus.data[OWN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  logic [RADIX_W-1:0] radix   [NDIG];
  logic               fixed   [NDIG];
  logic [ID_BITS-1:0] own_dig [NDIG];
  logic [DIMC_W-1:0]  used_dims;
  logic [ID_BITS+OWN_W-1:0] own_ext;
  logic               busy, adv;

  assign used_dims = (dimc_r > DIMC_W'(MAX_DIMS)) ? DIMC_W'(MAX_DIMS) : dimc_r;
  assign own_ext   = {{ID_BITS{1'b0}}, own_r};
  assign radix[0]  = conc_r;
  assign fixed[0]  = !mask_r[0];

  for (genvar k = 1; k < NDIG; k++) begin : g_dim
    assign radix[k] = grid_r[RADIX_W*(k-1) +: RADIX_W];
    assign fixed[k] = !mask_r[k] && (DIMC_W'(k) <= used_dims);
  end

  gspf_own_coords #(.MAX_DIMS(MAX_DIMS), .ID_BITS(ID_BITS)) u_own (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .own_id  (own_ext[ID_BITS-1:0]),
    .radix   (radix),
    .own_dig (own_dig),
    .busy    (busy)
  );

  assign in_bus.ready = adv && !busy && !start_r;

  gspf_digit_pipe #(.MAX_DIMS(MAX_DIMS), .ID_BITS(ID_BITS)) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid && in_bus.ready),
    .adv       (adv),
    .in_peer   (in_bus.peer_id),
    .in_last   (in_bus.last_in),
    .radix     (radix),
    .fixed     (fixed),
    .own_dig   (own_dig),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_peer  (out_bus.peer_out),
    .out_keep  (out_bus.keep),
    .out_last  (out_bus.last_out)
  );

endmodule

@@ src/gspf_own_coords.sv @@
// own coordinates: sequential bit-serial divider over all digits of own id
`timescale 1ns / 1ps
module gspf_own_coords import gspf_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ID_BITS-1:0] own_id,
  input  logic [RADIX_W-1:0] radix [MAX_DIMS+1],
  output logic [ID_BITS-1:0] own_dig [MAX_DIMS+1],
  output logic               busy
);

  localparam int NDIG  = MAX_DIMS + 1;
  localparam int KW    = $clog2(NDIG);
  localparam int CW    = $clog2(ID_BITS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [ID_BITS-1:0] acc_r, acc_nxt;
  logic [ID_BITS-1:0] orig_r, orig_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [ID_BITS-1:0] dig_r [NDIG];

  logic [RADIX_W-1:0] cur_radix;
  logic [RADIX_W:0]   tmp;
  logic               ge;
  logic [ID_BITS-1:0] res_dig, res_q;

  assign cur_radix = radix[k_r];
  assign tmp       = {rem_r, acc_r[ID_BITS-1]};
  assign ge        = tmp >= {1'b0, cur_radix};
  assign res_dig   = (cur_radix == '0) ? orig_r : ID_BITS'(rem_r);
  assign res_q     = (cur_radix == '0) ? '0 : acc_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    orig_nxt  = orig_r;
    rem_nxt   = rem_r;
    if (start) begin
      state_nxt = S_DIV;
      k_nxt     = '0;
      cnt_nxt   = '0;
      acc_nxt   = own_id;
      orig_nxt  = own_id;
      rem_nxt   = '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
        end
        S_DIV: begin
          rem_nxt = ge ? RADIX_W'(tmp - {1'b0, cur_radix}) : tmp[RADIX_W-1:0];
          acc_nxt = {acc_r[ID_BITS-2:0], ge};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(ID_BITS - 1)) begin
            state_nxt = S_DONE;
          end
        end
        S_DONE: begin
          acc_nxt  = res_q;
          orig_nxt = res_q;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          if (k_r == KW'(NDIG - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_DIV;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    orig_r <= orig_nxt;
    rem_r  <= rem_nxt;
  end

  // own id resets to zero, so every own coordinate is zero after reset
  for (genvar g = 0; g < NDIG; g++) begin : g_dig
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dig_r[g] <= '0;
      end else if (!start && state_r == S_DONE && k_r == KW'(g)) begin
        dig_r[g] <= res_dig;
      end
    end
    assign own_dig[g] = dig_r[g];
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ src/gspf_digit_pipe.sv @@
// digit pipeline: chained restoring dividers with per-digit compare and output register
`timescale 1ns / 1ps
module gspf_digit_pipe import gspf_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               adv,
  input  logic [PEER_W-1:0]  in_peer,
  input  logic               in_last,
  input  logic [RADIX_W-1:0] radix [MAX_DIMS+1],
  input  logic               fixed [MAX_DIMS+1],
  input  logic [ID_BITS-1:0] own_dig [MAX_DIMS+1],
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PEER_W-1:0]  out_peer,
  output logic               out_keep,
  output logic               out_last
);

  localparam int NDIG = MAX_DIMS + 1;
  localparam int SPD  = (ID_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int NS   = NDIG * SPD;

  logic               vld_r  [NS];
  logic [PEER_W-1:0]  peer_r [NS];
  logic               last_r [NS];
  logic [ID_BITS-1:0] acc_r  [NS];
  logic [ID_BITS-1:0] orig_r [NS];
  logic [RADIX_W-1:0] rem_r  [NS];
  logic               ok_r   [NS];

  logic [ID_BITS+PEER_W-1:0] peer_ext;
  assign peer_ext = {{ID_BITS{1'b0}}, in_peer};

  logic ovld_r, okeep_r, olast_r;
  logic [PEER_W-1:0] opeer_r;

  assign adv = !ovld_r || out_ready;

  for (genvar j = 0; j < NS; j++) begin : g_st
    localparam int D  = j / SPD;
    localparam int S  = j % SPD;
    localparam int DP = (D > 0) ? D - 1 : 0;
    localparam int NB = (ID_BITS - S * STEP_BITS) < STEP_BITS ?
                        (ID_BITS - S * STEP_BITS) : STEP_BITS;

    logic               vld_nxt, last_nxt, ok_nxt;
    logic [PEER_W-1:0]  peer_nxt;
    logic [ID_BITS-1:0] acc_nxt, orig_nxt, dig, q;
    logic [RADIX_W-1:0] rem_nxt;
    logic [RADIX_W:0]   tmp;
    logic               ge;

    always_comb begin
      dig = '0;
      q   = '0;
      tmp = '0;
      ge  = 1'b0;
      if (j == 0) begin
        vld_nxt  = in_valid;
        peer_nxt = in_peer;
        last_nxt = in_last;
        acc_nxt  = peer_ext[ID_BITS-1:0];
        orig_nxt = peer_ext[ID_BITS-1:0];
        rem_nxt  = '0;
        ok_nxt   = 1'b1;
      end else begin
        vld_nxt  = vld_r[j-1];
        peer_nxt = peer_r[j-1];
        last_nxt = last_r[j-1];
        acc_nxt  = acc_r[j-1];
        orig_nxt = orig_r[j-1];
        rem_nxt  = rem_r[j-1];
        ok_nxt   = ok_r[j-1];
        if (S == 0) begin
          // close the previous digit: zero radix takes the whole quotient
          if (radix[DP] == '0) begin
            dig = orig_nxt;
            q   = '0;
          end else begin
            dig = ID_BITS'(rem_nxt);
            q   = acc_nxt;
          end
          if (fixed[DP] && dig != own_dig[DP]) begin
            ok_nxt = 1'b0;
          end
          acc_nxt  = q;
          orig_nxt = q;
          rem_nxt  = '0;
        end
      end
      for (int i = 0; i < NB; i++) begin
        tmp     = {rem_nxt, acc_nxt[ID_BITS-1]};
        ge      = tmp >= {1'b0, radix[D]};
        rem_nxt = ge ? RADIX_W'(tmp - {1'b0, radix[D]}) : tmp[RADIX_W-1:0];
        acc_nxt = {acc_nxt[ID_BITS-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= vld_nxt;
      end
      if (adv) begin
        peer_r[j] <= peer_nxt;
        last_r[j] <= last_nxt;
        acc_r[j]  <= acc_nxt;
        orig_r[j] <= orig_nxt;
        rem_r[j]  <= rem_nxt;
        ok_r[j]   <= ok_nxt;
      end
    end
  end

  logic [ID_BITS-1:0] fin_dig;
  logic               fin_ok;

  always_comb begin
    fin_dig = (radix[NDIG-1] == '0) ? orig_r[NS-1] : ID_BITS'(rem_r[NS-1]);
    fin_ok  = ok_r[NS-1] && !(fixed[NDIG-1] && fin_dig != own_dig[NDIG-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv) begin
      ovld_r <= vld_r[NS-1];
    end
    if (adv) begin
      opeer_r <= peer_r[NS-1];
      okeep_r <= fin_ok;
      olast_r <= last_r[NS-1];
    end
  end

  assign out_valid = ovld_r;
  assign out_peer  = opeer_r;
  assign out_keep  = okeep_r;
  assign out_last  = olast_r;

endmodule
